// ----- sv/qrv_pkg.sv -----
// Shared widths, register codes and pipeline transaction types for the
// quaternion vector rotation unit. No dependencies.
package qrv_pkg;

	localparam int VEC_W   = 24;
	localparam int QUAT_W  = 16;
	localparam int SQ_W    = 2 * QUAT_W;
	localparam int NRM_W   = SQ_W + 2;
	localparam int VP_W    = QUAT_W + VEC_W;
	localparam int DT_W    = VP_W + 2;
	localparam int CR_W    = VP_W + 1;
	localparam int ACC_W   = NRM_W + VEC_W + 2;
	localparam int DEN_W   = NRM_W + 1;
	localparam int Q_W     = VEC_W;
	localparam int FRONT_ST = 5;
	localparam int NST     = FRONT_ST + Q_W + 1;
	localparam int NCOMP   = 3;

	localparam logic signed [QUAT_W-1:0] ONE_Q = QUAT_W'(1) << (QUAT_W - 2);

	typedef enum logic [1:0] {
		REG_W = 2'd0,
		REG_X = 2'd1,
		REG_Y = 2'd2,
		REG_Z = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [ACC_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [Q_W-1:0]   quo;
		logic             neg;
		logic             big;
	} div_step_t;

endpackage

// ----- sv/quaternion_rotate_vector_unit.sv -----
// Top level of the quaternion vector rotation unit: configuration registers,
// valid/ready pipeline control and output saturation.
// Depends on qrv_pkg, qrv_front and qrv_divider.
//
// Usage:
//   Write rot_w, rot_x, rot_y, rot_z (signed Q2.14) through cfg_we,
//   cfg_index and cfg_wdata while no transaction is in flight.
//   Each slave transaction carries one vector; each master transaction
//   returns the vector rotated by q * v * conj(q) / |q|^2, rounded half
//   away from zero and saturated to 24 bits. m_tuser flags a zero
//   quaternion, in which case m_tdata is zero.
// Pipeline: 30 register stages (five arithmetic, 24 divider stages at one
//   quotient bit each, one output stage).
// Throughput: one transaction per cycle while m_tready does not stall the output.
// Reset: clears all valid bits and loads the identity quaternion (1,0,0,0).
// Stall: each stage holds while its successor is full and not advancing;
//   bubbles are squeezed out, so s_tready drops only when all 30 stages are
//   full and m_tready is low.
module quaternion_rotate_vector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // vec_x, vec_y, vec_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_x, out_y, out_z
	output logic        m_tuser    // invalid
);
	import qrv_pkg::*;

	localparam logic [Q_W:0] LIM = (Q_W+1)'(1) << (VEC_W - 1);

	logic signed [QUAT_W-1:0] rot_w_q;
	logic signed [QUAT_W-1:0] rot_u_q [NCOMP];
	logic signed [VEC_W-1:0]  vec     [NCOMP];
	logic [NST-1:0]           vld_q;
	logic [NST-1:0]           en;
	div_step_t                front_out [NCOMP];
	div_step_t                div_out   [NCOMP];
	logic [VEC_W-1:0]         res       [NCOMP];
	logic [VEC_W*NCOMP-1:0]   tdata_q;
	logic                     tuser_q;
	logic                     zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w_q <= ONE_Q;
			for (int i = 0; i < NCOMP; i++) rot_u_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_W: rot_w_q    <= cfg_wdata;
				REG_X: rot_u_q[0] <= cfg_wdata;
				REG_Y: rot_u_q[1] <= cfg_wdata;
				REG_Z: rot_u_q[2] <= cfg_wdata;
				default: rot_w_q  <= rot_w_q;
			endcase
		end
	end

	assign zero_q = (rot_w_q == '0) && (rot_u_q[0] == '0) && (rot_u_q[1] == '0)
		&& (rot_u_q[2] == '0);

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NST-1];

	always_comb begin
		for (int i = 0; i < NCOMP; i++) vec[i] = s_tdata[i*VEC_W +: VEC_W];
	end

	qrv_front u_front (
		.clk   (clk),
		.en    (en[FRONT_ST-1:0]),
		.rot_w (rot_w_q),
		.rot_u (rot_u_q),
		.vec   (vec),
		.dout  (front_out)
	);

	for (genvar i = 0; i < NCOMP; i++) begin : g_div
		qrv_divider u_div (
			.clk  (clk),
			.en   (en[FRONT_ST +: Q_W]),
			.din  (front_out[i]),
			.dout (div_out[i])
		);
	end

	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			if (div_out[i].neg) begin
				if (div_out[i].big || ({1'b0, div_out[i].quo} > LIM)) begin
					res[i] = VEC_W'(LIM);
				end else begin
					res[i] = VEC_W'(~div_out[i].quo + 1'b1);
				end
			end else begin
				if (div_out[i].big || ({1'b0, div_out[i].quo} > LIM - 1'b1)) begin
					res[i] = VEC_W'(LIM - 1'b1);
				end else begin
					res[i] = div_out[i].quo;
				end
			end
			if (zero_q) res[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			for (int i = 0; i < NCOMP; i++) tdata_q[i*VEC_W +: VEC_W] <= res[i];
			tuser_q <= zero_q;
		end
	end

	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

`ifndef NO_ASSERTIONS
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("invalid result carries nonzero data");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input stalled with a bubble in the pipeline");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted transaction lost at first stage");
`endif

endmodule

// ----- sv/qrv_front.sv -----
// Products, sums and rounding setup: pipeline stages 1 to 5.
// Depends on qrv_pkg; feeds one qrv_divider per component.
module qrv_front (
	input  logic                                  clk,
	input  logic [qrv_pkg::FRONT_ST-1:0]          en,
	input  logic signed [qrv_pkg::QUAT_W-1:0]     rot_w,
	input  logic signed [qrv_pkg::QUAT_W-1:0]     rot_u [qrv_pkg::NCOMP],
	input  logic signed [qrv_pkg::VEC_W-1:0]      vec   [qrv_pkg::NCOMP],
	output qrv_pkg::div_step_t                    dout  [qrv_pkg::NCOMP]
);
	import qrv_pkg::*;

	logic signed [SQ_W-1:0]  ww_s1;
	logic signed [SQ_W-1:0]  sq_s1 [NCOMP];
	logic signed [VP_W-1:0]  p_s1  [NCOMP][NCOMP];
	logic signed [VEC_W-1:0] v_s1  [NCOMP];

	logic signed [NRM_W-1:0] nrm_s2, s_s2;
	logic signed [DT_W-1:0]  dt_s2;
	logic signed [CR_W-1:0]  cr_s2 [NCOMP];
	logic signed [VEC_W-1:0] v_s2  [NCOMP];

	logic signed [NRM_W+VEC_W-1:0]  sa_p [NCOMP];
	logic signed [DT_W+QUAT_W-1:0]  dx_p [NCOMP];
	logic signed [CR_W+QUAT_W-1:0]  wc_p [NCOMP];
	logic signed [ACC_W-1:0] sa_s3 [NCOMP];
	logic signed [ACC_W-1:0] dx_s3 [NCOMP];
	logic signed [ACC_W-1:0] wc_s3 [NCOMP];
	logic signed [NRM_W-1:0] nrm_s3;

	logic signed [ACC_W-1:0] r_s4 [NCOMP];
	logic signed [NRM_W-1:0] nrm_s4;

	logic [ACC_W-1:0] mag  [NCOMP];
	logic [ACC_W-1:0] numr [NCOMP];
	logic [DEN_W-1:0] den;
	logic [ACC_W-1:0] den_top;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ww_s1 <= rot_w * rot_w;
			for (int i = 0; i < NCOMP; i++) begin
				sq_s1[i] <= rot_u[i] * rot_u[i];
				v_s1[i]  <= vec[i];
				for (int j = 0; j < NCOMP; j++) begin
					p_s1[i][j] <= rot_u[i] * vec[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			nrm_s2 <= NRM_W'(ww_s1) + NRM_W'(sq_s1[0]) + NRM_W'(sq_s1[1])
				+ NRM_W'(sq_s1[2]);
			s_s2   <= NRM_W'(ww_s1) - NRM_W'(sq_s1[0]) - NRM_W'(sq_s1[1])
				- NRM_W'(sq_s1[2]);
			dt_s2  <= DT_W'(p_s1[0][0]) + DT_W'(p_s1[1][1]) + DT_W'(p_s1[2][2]);
			cr_s2[0] <= CR_W'(p_s1[1][2]) - CR_W'(p_s1[2][1]);
			cr_s2[1] <= CR_W'(p_s1[2][0]) - CR_W'(p_s1[0][2]);
			cr_s2[2] <= CR_W'(p_s1[0][1]) - CR_W'(p_s1[1][0]);
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			sa_p[i] = s_s2 * v_s2[i];
			dx_p[i] = dt_s2 * rot_u[i];
			wc_p[i] = rot_w * cr_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < NCOMP; i++) begin
				sa_s3[i] <= ACC_W'(sa_p[i]);
				dx_s3[i] <= ACC_W'(dx_p[i]);
				wc_s3[i] <= ACC_W'(wc_p[i]);
			end
			nrm_s3 <= nrm_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < NCOMP; i++) begin
				r_s4[i] <= sa_s3[i] + (dx_s3[i] <<< 1) + (wc_s3[i] <<< 1);
			end
			nrm_s4 <= nrm_s3;
		end
	end

	always_comb begin
		den     = DEN_W'(nrm_s4) << 1;
		den_top = ACC_W'(den) << Q_W;
		for (int i = 0; i < NCOMP; i++) begin
			mag[i]  = r_s4[i][ACC_W-1] ? ACC_W'(-r_s4[i]) : ACC_W'(r_s4[i]);
			numr[i] = (mag[i] << 1) + ACC_W'(nrm_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < NCOMP; i++) begin
				dout[i].rem <= numr[i];
				dout[i].den <= den;
				dout[i].quo <= '0;
				dout[i].neg <= r_s4[i][ACC_W-1];
				dout[i].big <= numr[i] >= den_top;
			end
		end
	end

endmodule

// ----- sv/qrv_divider.sv -----
// Restoring divider, one quotient bit per pipeline stage.
// Depends on qrv_pkg; used by the top level once per component.
module qrv_divider (
	input  logic                    clk,
	input  logic [qrv_pkg::Q_W-1:0] en,
	input  qrv_pkg::div_step_t      din,
	output qrv_pkg::div_step_t      dout
);
	import qrv_pkg::*;

	div_step_t step_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		localparam int SH = Q_W - 1 - j;
		div_step_t        cur;
		div_step_t        nxt;
		logic [ACC_W-1:0] sub;
		logic             take;

		assign cur  = (j == 0) ? din : step_s[(j == 0) ? 0 : j - 1];
		assign sub  = ACC_W'(cur.den) << SH;
		assign take = cur.rem >= sub;

		always_comb begin
			nxt         = cur;
			nxt.rem     = take ? cur.rem - sub : cur.rem;
			nxt.quo[SH] = take;
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				step_s[j] <= nxt;
			end
		end
	end

	assign dout = step_s[Q_W-1];

endmodule

// ----- tb/tb_quaternion_rotate_vector_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_rotate_vector_unit: random vector streams
// under several rotation quaternions, checked against an exact integer rotation predictor.
// Depends on qrv_pkg and the quaternion_rotate_vector_unit RTL.
module tb_quaternion_rotate_vector_unit;
	import qrv_pkg::*;

	typedef struct {
		logic signed [VEC_W-1:0] x, y, z;
	} vec_t;

	typedef struct {
		logic [VEC_W-1:0] x, y, z;
		logic             inv;
	} rot_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // vec_x, vec_y, vec_z
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // out_x, out_y, out_z
	logic        m_tuser;   // invalid

	quaternion_rotate_vector_unit dut (.*);

	logic signed [QUAT_W-1:0] quat [4];
	vec_t     pending_vecs[$];
	rot_res_t rotated_q[$];
	vec_t     drv_vec;
	int       src_gap;
	int       sink_gap;
	bit       burst;
	int       errors;
	int       quiet_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [VEC_W-1:0] round_sat(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] mag;
		logic signed [127:0] q;
		logic signed [127:0] lim;
		lim = 128'sd1 <<< (VEC_W - 1);
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		if (num < 0) begin
			if (q > lim)
				q = lim;
			return VEC_W'(-q);
		end
		if (q > lim - 1)
			q = lim - 1;
		return VEC_W'(q);
	endfunction

	function automatic rot_res_t rotate(vec_t v);
		logic signed [127:0] w, x, y, z, a, b, c, uu, ww, nrm, s, dt, cx, cy, cz;
		rot_res_t r;
		w = quat[REG_W]; x = quat[REG_X]; y = quat[REG_Y]; z = quat[REG_Z];
		a = v.x; b = v.y; c = v.z;
		uu = x * x + y * y + z * z;
		ww = w * w;
		nrm = ww + uu;
		if (nrm == 0) begin
			r.x = '0; r.y = '0; r.z = '0; r.inv = 1'b1;
			return r;
		end
		s = ww - uu;
		dt = x * a + y * b + z * c;
		cx = y * c - z * b;
		cy = z * a - x * c;
		cz = x * b - y * a;
		r.x = round_sat(s * a + 2 * dt * x + 2 * w * cx, nrm);
		r.y = round_sat(s * b + 2 * dt * y + 2 * w * cy, nrm);
		r.z = round_sat(s * c + 2 * dt * z + 2 * w * cz, nrm);
		r.inv = 1'b0;
		return r;
	endfunction

	task automatic report(string what, logic [VEC_W-1:0] got, logic [VEC_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				rotated_q.push_back(rotate(drv_vec));
			if (!(s_tvalid && !s_tready)) begin
				if (src_gap > 0) begin
					src_gap  <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_vecs.size() > 0) begin
					drv_vec = pending_vecs.pop_front();
					s_tdata  <= {drv_vec.z, drv_vec.y, drv_vec.x};
					s_tvalid <= 1'b1;
					src_gap  <= burst ? 0 : $urandom_range(0, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rot_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rotated_q.size() == 0) begin
					$display("unexpected result transaction at %0t", $realtime);
					errors++;
				end else begin
					want = rotated_q.pop_front();
					if (m_tdata[23:0] !== want.x)
						report("out_x", m_tdata[23:0], want.x);
					if (m_tdata[47:24] !== want.y)
						report("out_y", m_tdata[47:24], want.y);
					if (m_tdata[71:48] !== want.z)
						report("out_z", m_tdata[71:48], want.z);
					if (m_tuser !== want.inv)
						report("invalid", VEC_W'(m_tuser), VEC_W'(want.inv));
				end
			end
			if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					sink_gap <= burst ? 0 : $urandom_range(0, 3);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(pending_vecs.size() == 0 && !s_tvalid && rotated_q.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 2000) begin
			$display("tb_quaternion_rotate_vector_unit: errors");
			$finish;
		end
	end

	task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		quat[idx] = val;
	endtask

	task automatic load_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
			logic [15:0] z);
		cfg_write(REG_W, w);
		cfg_write(REG_X, x);
		cfg_write(REG_Y, y);
		cfg_write(REG_Z, z);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VEC_W-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return VEC_W'($urandom_range(0, 64)) - 24'd32;
			default: return VEC_W'($urandom);
		endcase
	endfunction

	task automatic queue_random(int n);
		vec_t v;
		for (int i = 0; i < n; i++) begin
			v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
			pending_vecs.push_back(v);
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_vecs.size() > 0 || s_tvalid || rotated_q.size() > 0);
	endtask

	initial begin
		logic signed [VEC_W-1:0] corner [6];
		vec_t v;
		corner = '{24'sh800000, 24'sh7fffff, 24'sh0, 24'sh1, -24'sh1, 24'sh555555};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_W;
		cfg_wdata = '0;
		burst = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		quat[REG_W] = ONE_Q;
		quat[REG_X] = '0;
		quat[REG_Y] = '0;
		quat[REG_Z] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 6; i++) begin
			v.x = corner[i]; v.y = corner[(i + 1) % 6]; v.z = corner[(i + 3) % 6];
			pending_vecs.push_back(v);
		end
		queue_random(40);
		drain();

		// extremes, zero norm, tiny norm, half-turns, a quarter-turn, then random rotations
		load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		for (int i = 0; i < 6; i++) begin
			v.x = corner[i]; v.y = corner[(i + 2) % 6]; v.z = corner[(i + 5) % 6];
			pending_vecs.push_back(v);
		end
		queue_random(120);
		drain();
		load_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		queue_random(120);
		drain();
		load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_random(60);
		drain();
		load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0001);
		queue_random(100);
		drain();
		load_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		queue_random(100);
		drain();
		load_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
		queue_random(100);
		drain();
		load_quat(16'h2d41, 16'h0000, 16'h2d41, 16'h0000);
		queue_random(100);
		drain();
		for (int p = 0; p < 10; p++) begin
			load_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			burst = (p % 3 == 1);
			queue_random(90);
			drain();
		end
		burst = 1'b0;

		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb_quaternion_rotate_vector_unit: clean");
		else
			$display("tb_quaternion_rotate_vector_unit: errors");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/qrv_pkg.sv
sv/qrv_front.sv
sv/qrv_divider.sv
sv/quaternion_rotate_vector_unit.sv
tb/tb_quaternion_rotate_vector_unit.sv
